[sv/tsdd_pkg.sv]
// ----------------------------------------------------------------------------
// tsdd_pkg
// Shared codes, register indexes and fixed widths for the swipe detector.
// ----------------------------------------------------------------------------
`default_nettype none

package tsdd_pkg;

    localparam int OP_W   = 2;
    localparam int DIR_W  = 3;
    localparam int IDX_W  = 2;
    localparam int DATA_W = 13;

    localparam int THR_W  = 12;
    localparam int XMIN_W = 12;
    localparam int XMAX_W = 13;
    localparam int YMAX_W = 13;

    typedef logic [OP_W-1:0]   op_t;
    typedef logic [DIR_W-1:0]  dir_t;
    typedef logic [IDX_W-1:0]  reg_idx_t;
    typedef logic [DATA_W-1:0] reg_data_t;

    localparam op_t OP_X       = 2'd0;
    localparam op_t OP_Y       = 2'd1;
    localparam op_t OP_PRESS   = 2'd2;
    localparam op_t OP_RELEASE = 2'd3;

    localparam dir_t DIR_NONE  = 3'd0;
    localparam dir_t DIR_UP    = 3'd1;
    localparam dir_t DIR_DOWN  = 3'd2;
    localparam dir_t DIR_LEFT  = 3'd3;
    localparam dir_t DIR_RIGHT = 3'd4;

    localparam reg_idx_t REG_THRESHOLD  = 2'd0;
    localparam reg_idx_t REG_ZONE_X_MIN = 2'd1;
    localparam reg_idx_t REG_ZONE_X_MAX = 2'd2;
    localparam reg_idx_t REG_ZONE_Y_MAX = 2'd3;

    localparam logic [THR_W-1:0]  THRESHOLD_RST  = 12'd100;
    localparam logic [XMIN_W-1:0] ZONE_X_MIN_RST = 12'd736;
    localparam logic [XMAX_W-1:0] ZONE_X_MAX_RST = 13'd800;
    localparam logic [YMAX_W-1:0] ZONE_Y_MAX_RST = 13'd90;

endpackage

`default_nettype wire

[sv/tsdd_if.sv]
// ----------------------------------------------------------------------------
// tsdd_if
// Valid/ready channels of the swipe detector: events, results, config writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsdd_evt_if
    import tsdd_pkg::*;
#(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    op_t                   operation;
    logic [COORD_BITS-1:0] coordinate;

    modport source (output valid, output operation, output coordinate, input ready);
    modport sink   (input valid, input operation, input coordinate, output ready);
endinterface

interface tsdd_res_if
    import tsdd_pkg::*;
;
    logic valid;
    logic ready;
    dir_t direction;

    modport source (output valid, output direction, input ready);
    modport sink   (input valid, input direction, output ready);
endinterface

interface tsdd_cfg_if
    import tsdd_pkg::*;
;
    logic      valid;
    logic      ready;
    reg_idx_t  index;
    reg_data_t data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[sv/touch_swipe_direction_detector_unit.sv]
// ----------------------------------------------------------------------------
// touch_swipe_direction_detector_unit
// Tracks touch coordinates and turns press/release events into swipe results.
// ----------------------------------------------------------------------------
// A result is registered: it appears in the output register in the cycle after its event is accepted.
// Throughput: one event per cycle; the only stall is a held result on res.
// Per-event work is a few subtractions and compares between state and result regs.
// Reset: coordinates go to unknown (-1), registers to 100/736/800/90, no result.
`default_nettype none

module touch_swipe_direction_detector_unit
    import tsdd_pkg::*;
#(
    parameter int COORD_BITS = 12
)(
    input  wire        clk,
    input  wire        rst_n,
    tsdd_evt_if.sink   evt,
    tsdd_res_if.source res,
    tsdd_cfg_if.sink   cfg
);

    // compare width: signed coordinate difference and 13-bit zone edges
    localparam int CMP_W = (COORD_BITS + 2 > YMAX_W + 1) ? COORD_BITS + 2 : YMAX_W + 1;
    localparam int ST_W  = COORD_BITS + 1;

    logic signed [ST_W-1:0] cx_reg, cy_reg, sx_reg, sy_reg;
    logic signed [ST_W-1:0] cx_next, cy_next, sx_next, sy_next;

    logic [THR_W-1:0]  thr_reg;
    logic [XMIN_W-1:0] xmin_reg;
    logic [XMAX_W-1:0] xmax_reg;
    logic [YMAX_W-1:0] ymax_reg;

    logic res_valid_reg, res_valid_next;
    dir_t dir_reg, dir_next;

    logic evt_acc, cfg_acc;
    logic signed [ST_W-1:0]  coord_s;
    logic signed [CMP_W-1:0] cxw, cyw, sxw, syw, pxw, pyw;
    logic signed [CMP_W-1:0] dx, dy, adx, ady;
    logic signed [CMP_W-1:0] thr_w, xmin_w, xmax_w, ymax_w;
    logic in_zone, emit;
    dir_t rel_dir;

    assign evt.ready = !res_valid_reg || res.ready;
    assign evt_acc   = evt.valid && evt.ready;
    assign cfg.ready = 1'b1;
    assign cfg_acc   = cfg.valid;

    assign res.valid     = res_valid_reg;
    assign res.direction = dir_reg;

    assign coord_s = signed'({1'b0, evt.coordinate});

    assign cxw = {{(CMP_W-ST_W){cx_reg[ST_W-1]}}, cx_reg};
    assign cyw = {{(CMP_W-ST_W){cy_reg[ST_W-1]}}, cy_reg};
    assign sxw = {{(CMP_W-ST_W){sx_reg[ST_W-1]}}, sx_reg};
    assign syw = {{(CMP_W-ST_W){sy_reg[ST_W-1]}}, sy_reg};

    assign thr_w  = signed'({{(CMP_W-THR_W){1'b0}}, thr_reg});
    assign xmin_w = signed'({{(CMP_W-XMIN_W){1'b0}}, xmin_reg});
    assign xmax_w = signed'({{(CMP_W-XMAX_W){1'b0}}, xmax_reg});
    assign ymax_w = signed'({{(CMP_W-YMAX_W){1'b0}}, ymax_reg});

    // press latches the current point as start; zone test on that point
    assign pxw = cxw;
    assign pyw = cyw;
    assign in_zone = (pxw >= xmin_w) && (pxw < xmax_w) &&
                     !pyw[CMP_W-1] && (pyw < ymax_w);

    assign dx  = cxw - sxw;
    assign dy  = cyw - syw;
    assign adx = dx[CMP_W-1] ? -dx : dx;
    assign ady = dy[CMP_W-1] ? -dy : dy;

    always_comb
    begin
        rel_dir = DIR_NONE;
        if (adx > ady)
        begin
            if (adx > thr_w)
                rel_dir = dx[CMP_W-1] ? DIR_LEFT : DIR_RIGHT;
        end
        else if (ady > adx)
        begin
            if (ady > thr_w)
                rel_dir = dy[CMP_W-1] ? DIR_UP : DIR_DOWN;
        end
    end

    always_comb
    begin
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        emit           = 1'b0;
        dir_next       = dir_reg;
        res_valid_next = res_valid_reg && !res.ready;
        if (evt_acc)
        begin
            unique case (evt.operation)
                OP_X:
                begin
                    cx_next = coord_s;
                end
                OP_Y:
                begin
                    cy_next = coord_s;
                end
                OP_PRESS:
                begin
                    sx_next = cx_reg;
                    sy_next = cy_reg;
                    if (in_zone)
                    begin
                        emit     = 1'b1;
                        dir_next = DIR_UP;
                    end
                end
                OP_RELEASE:
                begin
                    emit     = 1'b1;
                    dir_next = rel_dir;
                end
                default:
                begin
                end
            endcase
            if (emit)
            begin
                cx_next        = '1;
                cy_next        = '1;
                sx_next        = '1;
                sy_next        = '1;
                res_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg        <= '1;
            cy_reg        <= '1;
            sx_reg        <= '1;
            sy_reg        <= '1;
            res_valid_reg <= 1'b0;
            dir_reg       <= DIR_NONE;
        end
        else
        begin
            cx_reg        <= cx_next;
            cy_reg        <= cy_next;
            sx_reg        <= sx_next;
            sy_reg        <= sy_next;
            res_valid_reg <= res_valid_next;
            dir_reg       <= dir_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THRESHOLD_RST;
            xmin_reg <= ZONE_X_MIN_RST;
            xmax_reg <= ZONE_X_MAX_RST;
            ymax_reg <= ZONE_Y_MAX_RST;
        end
        else if (cfg_acc)
        begin
            unique case (cfg.index)
                REG_THRESHOLD:  thr_reg  <= cfg.data[THR_W-1:0];
                REG_ZONE_X_MIN: xmin_reg <= cfg.data[XMIN_W-1:0];
                REG_ZONE_X_MAX: xmax_reg <= cfg.data[XMAX_W-1:0];
                REG_ZONE_Y_MAX: ymax_reg <= cfg.data[YMAX_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    // a release always produces an item
    a_release_result: assert property (@(posedge clk) disable iff (!rst_n)
        evt_acc && evt.operation == OP_RELEASE |=> res_valid_reg)
        else $error("release did not produce a result");

    // every emitted item returns all coordinates to unknown
    a_clear_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (cx_reg == '1) && (cy_reg == '1) && (sx_reg == '1) && (sy_reg == '1))
        else $error("coordinates not cleared after result");

    // an x event loads the coordinate
    a_x_load: assert property (@(posedge clk) disable iff (!rst_n)
        evt_acc && evt.operation == OP_X |=> cx_reg == $past(coord_s))
        else $error("x position not captured");

    // a zone press yields UP
    a_zone_up: assert property (@(posedge clk) disable iff (!rst_n)
        evt_acc && evt.operation == OP_PRESS && in_zone |=> dir_reg == DIR_UP)
        else $error("zone press did not give up");

    // an unknown start coordinate never lies in the zone
    a_unknown_out: assert property (@(posedge clk) disable iff (!rst_n)
        cx_reg == '1 |-> !in_zone)
        else $error("unknown point found in zone");
`endif

endmodule

`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the touch swipe detector. Position, press and release
// items are sent with random gaps and random result back-pressure. A scoreboard
// tracks the touch state and the zone and threshold registers, predicts each
// direction and checks the results in order. The registers are rewritten
// between phases, including the extreme settings.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tsdd_pkg::*;

    localparam int COORD_BITS = 12;
    localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
    localparam int PHASES     = 7;
    localparam int PHASE_LEN  = 250;

    typedef logic [COORD_BITS-1:0]      coord_t;
    typedef logic signed [COORD_BITS:0] pos_t;

    class swipe_scoreboard;
        pos_t              cur_x;
        pos_t              cur_y;
        pos_t              start_x;
        pos_t              start_y;
        logic [THR_W-1:0]  threshold;
        logic [XMIN_W-1:0] x_min;
        logic [XMAX_W-1:0] x_max;
        logic [YMAX_W-1:0] y_max;
        dir_t              expected_dirs[$];
        int                errors;

        function new();
            threshold = THRESHOLD_RST;
            x_min     = ZONE_X_MIN_RST;
            x_max     = ZONE_X_MAX_RST;
            y_max     = ZONE_Y_MAX_RST;
            errors    = 0;
            forget_points();
        endfunction

        function void forget_points();
            cur_x   = -1;
            cur_y   = -1;
            start_x = -1;
            start_y = -1;
        endfunction

        function void set_reg(reg_idx_t idx, reg_data_t data);
            case (idx)
                REG_THRESHOLD:  threshold = data[THR_W-1:0];
                REG_ZONE_X_MIN: x_min     = data[XMIN_W-1:0];
                REG_ZONE_X_MAX: x_max     = data[XMAX_W-1:0];
                REG_ZONE_Y_MAX: y_max     = data[YMAX_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_event(op_t op, coord_t coord);
            int   sx;
            int   sy;
            int   dx;
            int   dy;
            dir_t dir;
            case (op)
                OP_X: cur_x = {1'b0, coord};
                OP_Y: cur_y = {1'b0, coord};
                OP_PRESS:
                begin
                    start_x = cur_x;
                    start_y = cur_y;
                    sx = start_x;
                    sy = start_y;
                    // unknown (-1) start never lands in the zone
                    if (sx >= int'(x_min) && sx < int'(x_max) && sy >= 0 && sy < int'(y_max))
                    begin
                        expected_dirs.push_back(DIR_UP);
                        forget_points();
                    end
                end
                default:
                begin
                    dx  = int'(cur_x) - int'(start_x);
                    dy  = int'(cur_y) - int'(start_y);
                    dx  = (dx < 0) ? -dx : dx;
                    dy  = (dy < 0) ? -dy : dy;
                    dir = DIR_NONE;
                    if (dx > dy)
                    begin
                        if (dx > int'(threshold))
                            dir = (cur_x > start_x) ? DIR_RIGHT : DIR_LEFT;
                    end
                    else if (dy > dx)
                    begin
                        if (dy > int'(threshold))
                            dir = (cur_y > start_y) ? DIR_DOWN : DIR_UP;
                    end
                    expected_dirs.push_back(dir);
                    forget_points();
                end
            endcase
        endfunction

        function void check_result(dir_t got);
            dir_t want;
            if (expected_dirs.size() == 0)
            begin
                $error("unexpected result: direction actual %0d", got);
                errors++;
            end
            else
            begin
                want = expected_dirs.pop_front();
                if (got !== want)
                begin
                    $error("direction mismatch: expected %0d, actual %0d", want, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_dirs.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    tsdd_evt_if #(.COORD_BITS(COORD_BITS)) evt_ch();
    tsdd_res_if                             res_ch();
    tsdd_cfg_if                             cfg_ch();

    touch_swipe_direction_detector_unit #(.COORD_BITS(COORD_BITS)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    swipe_scoreboard sb = new();

    int items_sent  = 0;
    int hold_cycles = 0;
    bit tx_steady   = 0;
    bit rx_steady   = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("simulation failed");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (tx_steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // step size along one axis, biased toward the threshold boundary
    function automatic int pick_mag();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return int'(sb.threshold);
            2:       return int'(sb.threshold) + 1;
            3:       return $urandom_range(0, 20);
            default: return $urandom_range(0, COORD_MAX);
        endcase
    endfunction

    function automatic int move_from(int start, int mag);
        int p;
        p = $urandom_range(0, 1) ? start + mag : start - mag;
        if (p > COORD_MAX)
            p = start - mag;
        if (p < 0)
            p = start + mag;
        if (p > COORD_MAX)
            p = COORD_MAX;
        if (p < 0)
            p = 0;
        return p;
    endfunction

    task automatic send_event(op_t op, coord_t coord);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            evt_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        evt_ch.valid      <= 1'b1;
        evt_ch.operation  <= op;
        evt_ch.coordinate <= coord;
        do @(posedge clk); while (!evt_ch.ready);
        sb.note_event(op, coord);
        items_sent++;
    endtask

    task automatic send_swipe();
        int sx;
        int sy;
        int ex;
        int ey;
        int mx;
        int my;
        int xhi;
        int yhi;
        int wander;
        xhi = ((int'(sb.x_max) > COORD_MAX + 1) ? COORD_MAX + 1 : int'(sb.x_max)) - 1;
        yhi = ((int'(sb.y_max) > COORD_MAX + 1) ? COORD_MAX + 1 : int'(sb.y_max)) - 1;
        if ($urandom_range(0, 3) == 0 && int'(sb.x_min) <= xhi && yhi >= 0)
        begin
            sx = $urandom_range(int'(sb.x_min), xhi);
            sy = $urandom_range(0, yhi);
        end
        else
        begin
            sx = $urandom_range(0, COORD_MAX);
            sy = $urandom_range(0, COORD_MAX);
        end
        mx = pick_mag();
        my = ($urandom_range(0, 4) == 0) ? mx : pick_mag();
        ex = move_from(sx, mx);
        ey = move_from(sy, my);

        // now and then skip a start coordinate so stale or unknown values are used
        if ($urandom_range(0, 7) != 0)
            send_event(OP_X, coord_t'(sx));
        if ($urandom_range(0, 7) != 0)
            send_event(OP_Y, coord_t'(sy));
        send_event(OP_PRESS, coord_t'($urandom_range(0, COORD_MAX)));
        wander = $urandom_range(0, 2);
        repeat (wander)
            send_event(op_t'($urandom_range(0, 1)), coord_t'($urandom_range(0, COORD_MAX)));
        if ($urandom_range(0, 1))
        begin
            send_event(OP_X, coord_t'(ex));
            send_event(OP_Y, coord_t'(ey));
        end
        else
        begin
            send_event(OP_Y, coord_t'(ey));
            send_event(OP_X, coord_t'(ex));
        end
        send_event(OP_RELEASE, coord_t'($urandom_range(0, COORD_MAX)));
    endtask

    task automatic apply_setting(reg_data_t thr, reg_data_t xmin, reg_data_t xmax,
                                 reg_data_t ymax);
        reg_idx_t  idxs[4];
        reg_data_t vals[4];
        idxs = '{REG_THRESHOLD, REG_ZONE_X_MIN, REG_ZONE_X_MAX, REG_ZONE_Y_MAX};
        vals = '{thr, xmin, xmax, ymax};
        evt_ch.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (3) @(posedge clk);
        for (int i = 0; i < 4; i++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idxs[i];
            cfg_ch.data  <= vals[i];
            do @(posedge clk); while (!cfg_ch.ready);
            sb.set_reg(idxs[i], vals[i]);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // result side: back-pressure and checking
    initial
    begin
        int stall_left;
        stall_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
                sb.check_result(res_ch.direction);
            if (hold_cycles > 0)
            begin
                stall_left  = hold_cycles;
                hold_cycles = 0;
            end
            else if (stall_left == 0 && !rx_steady && $urandom_range(0, 5) == 0)
            begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(1, 3);
            end
            if (stall_left > 0)
            begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        op_t    dir_ops[25];
        coord_t dir_coords[25];
        int     phase_end;
        int     waited;

        dir_ops = '{
            OP_RELEASE,                          // release with everything unknown
            OP_PRESS, OP_RELEASE,                // press with unknown start
            OP_X, OP_Y, OP_PRESS,                // press inside the corner zone
            OP_X, OP_Y, OP_PRESS,                // zone edges, inclusive side
            OP_X, OP_Y, OP_PRESS, OP_RELEASE,    // exclusive right edge, no movement
            OP_X, OP_Y, OP_PRESS, OP_X, OP_RELEASE,
            OP_X, OP_RELEASE,                    // unknown start takes part in the math
            OP_Y, OP_X, OP_PRESS, OP_Y, OP_RELEASE
        };
        dir_coords = '{
            12'd4095,
            12'd0, 12'd4095,
            12'd760, 12'd0, 12'd0,
            12'd736, 12'd89, 12'd4095,
            12'd800, 12'd0, 12'd0, 12'd0,
            12'd0, 12'd0, 12'd0, 12'd4095, 12'd0,
            12'd4095, 12'd0,
            12'd4095, 12'd2000, 12'd0, 12'd3000, 12'd4095
        };

        rst_n             <= 1'b0;
        evt_ch.valid      <= 1'b0;
        evt_ch.operation  <= OP_X;
        evt_ch.coordinate <= '0;
        res_ch.ready      <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= REG_THRESHOLD;
        cfg_ch.data       <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_ops[i])
            send_event(dir_ops[i], dir_coords[i]);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: ;
                1: apply_setting(13'd0, 13'd0, 13'd4096, 13'd4096);
                2: apply_setting(13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF);
                3: apply_setting(13'h1000, 13'd0, 13'd0, 13'd0);
                default:
                begin
                    int xmin;
                    int xmax;
                    xmin = $urandom_range(0, 3800);
                    xmax = xmin + $urandom_range(0, 600);
                    if (xmax > COORD_MAX + 1)
                        xmax = COORD_MAX + 1;
                    apply_setting(reg_data_t'($urandom_range(0, 300) + 4096 * $urandom_range(0, 1)),
                                  reg_data_t'(xmin), reg_data_t'(xmax),
                                  reg_data_t'($urandom_range(0, 700)));
                end
            endcase
            tx_steady = (phase == 3);
            rx_steady = (phase == 3);
            // long receiver hold so the output register fills and input stalls
            if (phase == 2)
                hold_cycles = 300;
            phase_end = items_sent + PHASE_LEN;
            while (items_sent < phase_end)
            begin
                if ($urandom_range(0, 3) != 0)
                    send_swipe();
                else
                    send_event(op_t'($urandom_range(0, 3)),
                               coord_t'($urandom_range(0, COORD_MAX)));
            end
        end
        evt_ch.valid <= 1'b0;

        waited = 0;
        while (sb.pending() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (5) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("%0d expected directions never arrived", sb.pending());
            sb.errors++;
        end

        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[touch_swipe_direction_detector_unit.f]
sv/tsdd_pkg.sv
sv/tsdd_if.sv
sv/touch_swipe_direction_detector_unit.sv
tb/testbench.sv
